### rtl/sm4x4_pkg.sv
// Package for the four-lane SM4 ECB block: sizes, request and response types,
// S-box table and round function. No dependencies.
`timescale 1ns / 1ps

package sm4x4_pkg;

    localparam int ROUNDS    = 32;
    localparam int LANES     = 4;
    localparam int KEY_IDX_W = $clog2(ROUNDS);
    localparam int BLOCK_W   = 128;

    localparam logic REQ_KEY_WRITE = 1'b0;
    localparam logic REQ_BLOCKS    = 1'b1;

    typedef logic [BLOCK_W-1:0] t_block;

    typedef struct packed {
        logic        req_type;
        logic        decrypt;
        logic [4:0]  key_index;
        logic [31:0] key_word;
        logic [63:0] in_block0_hi;
        logic [63:0] in_block0_lo;
        logic [63:0] in_block1_hi;
        logic [63:0] in_block1_lo;
        logic [63:0] in_block2_hi;
        logic [63:0] in_block2_lo;
        logic [63:0] in_block3_hi;
        logic [63:0] in_block3_lo;
    } t_in_req;

    typedef struct packed {
        logic [63:0] out_block0_hi;
        logic [63:0] out_block0_lo;
        logic [63:0] out_block1_hi;
        logic [63:0] out_block1_lo;
        logic [63:0] out_block2_hi;
        logic [63:0] out_block2_lo;
        logic [63:0] out_block3_hi;
        logic [63:0] out_block3_lo;
    } t_out_rsp;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        rotl32 = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] round_fn(input logic [31:0] a);
        logic [31:0] b;
        b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
        round_fn = b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
    endfunction

endpackage

### rtl/sm4x4_key_store.sv
// Round-key table: one write port, one read port at the current round.
// Depends on sm4x4_pkg.
`timescale 1ns / 1ps

module sm4x4_key_store
    import sm4x4_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [KEY_IDX_W-1:0] i_wr_idx,
    input  logic [31:0]          i_wr_data,
    input  logic [KEY_IDX_W-1:0] i_rd_idx,
    output logic [31:0]          o_rd_data
);

    logic [31:0] r_keys [ROUNDS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_keys[i_wr_idx] <= i_wr_data;
        end
    end

    assign o_rd_data = r_keys[i_rd_idx];

endmodule

### rtl/sm4x4_lane.sv
// One SM4 lane: holds the four state words of a block and runs one round a cycle.
// Depends on sm4x4_pkg.
`timescale 1ns / 1ps

module sm4x4_lane
    import sm4x4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  logic        i_step,
    input  t_block      i_block,
    input  logic [31:0] i_rk,
    output t_block      o_block
);

    logic [31:0] r_x0, r_x1, r_x2, r_x3;
    logic [31:0] n_x4;

    assign n_x4 = r_x0 ^ round_fn(r_x1 ^ r_x2 ^ r_x3 ^ i_rk);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x0 <= i_block[127:96];
            r_x1 <= i_block[95:64];
            r_x2 <= i_block[63:32];
            r_x3 <= i_block[31:0];
        end else if (i_step) begin
            r_x0 <= r_x1;
            r_x1 <= r_x2;
            r_x2 <= r_x3;
            r_x3 <= n_x4;
        end
    end

    // reverse word order on the way out
    assign o_block = {r_x3, r_x2, r_x1, r_x0};

endmodule

### rtl/sm4x4_merge.sv
// Output stage: gathers the lane results into one response and holds it
// until taken. Depends on sm4x4_pkg.
`timescale 1ns / 1ps

module sm4x4_merge
    import sm4x4_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_block   i_lane [LANES],
    output logic     o_free,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_out_rsp
);

    logic     r_valid;
    logic     n_valid;
    t_out_rsp r_rsp;
    t_out_rsp n_rsp;

    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid && i_out_stall;
        n_rsp   = r_rsp;
        if (i_load) begin
            n_valid             = 1'b1;
            n_rsp.out_block0_hi = i_lane[0][127:64];
            n_rsp.out_block0_lo = i_lane[0][63:0];
            n_rsp.out_block1_hi = i_lane[1][127:64];
            n_rsp.out_block1_lo = i_lane[1][63:0];
            n_rsp.out_block2_hi = i_lane[2][127:64];
            n_rsp.out_block2_lo = i_lane[2][63:0];
            n_rsp.out_block3_hi = i_lane[3][127:64];
            n_rsp.out_block3_lo = i_lane[3][63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_out_valid = r_valid;
    assign o_out_rsp   = r_rsp;

endmodule

### rtl/sm4_block_cipher_x4_top.sv
// Top level of the four-lane SM4 ECB block: control, key table, lanes, output.
// Depends on sm4x4_pkg, sm4x4_key_store, sm4x4_lane and sm4x4_merge.
//
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_req. A request with
//   req_type 0 writes key_word into round-key entry key_index and gives no
//   response. A request with req_type 1 encrypts (or, with decrypt set,
//   decrypts with the keys in reverse order) four blocks.
//   Output channel o_out_valid / i_out_stall / o_out_rsp carries one response
//   per block request.
//   A block request runs 32 rounds, one per cycle in each of the four lanes,
//   then goes into the output register once that is free; only then is a
//   new request accepted, so a block request must finish before the next
//   one is taken.
//   The output register holds a finished response while the receiver stalls,
//   and the next request is taken meanwhile; a second finished response waits
//   in the lanes until the register frees.
//   Reset empties the control and output valid; round keys are undefined
//   until written.
`timescale 1ns / 1ps

module sm4_block_cipher_x4_top
    import sm4x4_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_out_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [KEY_IDX_W-1:0] r_round, n_round;
    logic                 r_decrypt, n_decrypt;

    logic                 accept;
    logic                 key_wr;
    logic                 blk_load;
    logic                 step;
    logic                 merge_load;
    logic                 merge_free;
    logic [KEY_IDX_W-1:0] rk_idx;
    logic [31:0]          rk;
    t_block               lane_in  [LANES];
    t_block               lane_out [LANES];

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign key_wr     = accept && (i_in_req.req_type == REQ_KEY_WRITE);
    assign blk_load   = accept && (i_in_req.req_type == REQ_BLOCKS);
    assign step       = (r_state == S_RUN);
    assign merge_load = (r_state == S_DONE) && merge_free;
    assign rk_idx     = r_decrypt ? (KEY_IDX_W'(ROUNDS - 1) - r_round) : r_round;

    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_decrypt = r_decrypt;
        unique case (r_state)
            S_IDLE: begin
                if (blk_load) begin
                    n_state   = S_RUN;
                    n_round   = '0;
                    n_decrypt = i_in_req.decrypt;
                end
            end
            S_RUN: begin
                n_round = r_round + 1'b1;
                if (r_round == KEY_IDX_W'(ROUNDS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (merge_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
        r_decrypt <= n_decrypt;
    end

    sm4x4_key_store u_keys (
        .i_clk     (i_clk),
        .i_wr_en   (key_wr),
        .i_wr_idx  (i_in_req.key_index),
        .i_wr_data (i_in_req.key_word),
        .i_rd_idx  (rk_idx),
        .o_rd_data (rk)
    );

    assign lane_in[0] = {i_in_req.in_block0_hi, i_in_req.in_block0_lo};
    assign lane_in[1] = {i_in_req.in_block1_hi, i_in_req.in_block1_lo};
    assign lane_in[2] = {i_in_req.in_block2_hi, i_in_req.in_block2_lo};
    assign lane_in[3] = {i_in_req.in_block3_hi, i_in_req.in_block3_lo};

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        sm4x4_lane u_lane (
            .i_clk   (i_clk),
            .i_load  (blk_load),
            .i_step  (step),
            .i_block (lane_in[g]),
            .i_rk    (rk),
            .o_block (lane_out[g])
        );
    end

    sm4x4_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (merge_load),
        .i_lane      (lane_out),
        .o_free      (merge_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

### bench/sm4x4_cipher_monitor.sv
// Monitor for sm4_block_cipher_x4_top: tracks the round-key table, predicts each
// four-block response and compares accepted responses field by field.
// Depends on sm4x4_pkg for the request and response types.
`timescale 1ns / 1ps

module sm4x4_cipher_monitor
    import sm4x4_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in_req,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_rsp i_out_rsp,
    output int       o_fail_count,
    output int       o_pending
);

    localparam int FIELDS = 8;

    localparam logic [7:0] SUBST [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    string field_name [FIELDS] = '{
        "out_block0_hi", "out_block0_lo", "out_block1_hi", "out_block1_lo",
        "out_block2_hi", "out_block2_lo", "out_block3_hi", "out_block3_lo"
    };

    logic [31:0] round_key [ROUNDS];
    t_out_rsp    expected_rsp_q [$];

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {SUBST[w[31:24]], SUBST[w[23:16]], SUBST[w[15:8]], SUBST[w[7:0]]};
    endfunction

    function automatic logic [31:0] diffuse(input logic [31:0] b);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    function automatic logic [127:0] sm4_transform(input logic [127:0] blk, input logic reverse);
        logic [31:0] x0, x1, x2, x3, rk, nx;
        x0 = blk[127:96];
        x1 = blk[95:64];
        x2 = blk[63:32];
        x3 = blk[31:0];
        for (int r = 0; r < ROUNDS; r++) begin
            rk = reverse ? round_key[ROUNDS-1-r] : round_key[r];
            nx = x0 ^ diffuse(subst_word(x1 ^ x2 ^ x3 ^ rk));
            x0 = x1;
            x1 = x2;
            x2 = x3;
            x3 = nx;
        end
        return {x3, x2, x1, x0};
    endfunction

    function automatic t_out_rsp predict_blocks(input t_in_req q);
        return {sm4_transform({q.in_block0_hi, q.in_block0_lo}, q.decrypt),
                sm4_transform({q.in_block1_hi, q.in_block1_lo}, q.decrypt),
                sm4_transform({q.in_block2_hi, q.in_block2_lo}, q.decrypt),
                sm4_transform({q.in_block3_hi, q.in_block3_lo}, q.decrypt)};
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        logic [FIELDS*64-1:0] want_bits;
        logic [FIELDS*64-1:0] got_bits;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("unexpected response: %h", i_out_rsp);
                    o_fail_count++;
                end else begin
                    want_bits = expected_rsp_q.pop_front();
                    got_bits  = i_out_rsp;
                    for (int f = 0; f < FIELDS; f++) begin
                        if (got_bits[(FIELDS-1-f)*64 +: 64] !== want_bits[(FIELDS-1-f)*64 +: 64]) begin
                            $error("%s: expected %h, actual %h", field_name[f],
                                   want_bits[(FIELDS-1-f)*64 +: 64],
                                   got_bits[(FIELDS-1-f)*64 +: 64]);
                            o_fail_count++;
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_req.req_type == REQ_KEY_WRITE) begin
                    round_key[i_in_req.key_index] = i_in_req.key_word;
                end else begin
                    expected_rsp_q.push_back(predict_blocks(i_in_req));
                end
            end
            o_pending = expected_rsp_q.size();
        end
    end

endmodule

### bench/tb.sv
// Testbench top for sm4_block_cipher_x4_top: loads the round-key table, offers
// key writes and block requests with random gaps and back-pressure, gives the verdict.
// Depends on sm4x4_pkg, sm4x4_cipher_monitor and the block itself.
`timescale 1ns / 1ps

module tb;
    import sm4x4_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int DRAIN_GUARD  = 10000;

    logic     i_clk;
    logic     i_rst_n;
    logic     in_valid;
    logic     in_stall;
    t_in_req  in_req;
    logic     out_valid;
    logic     out_stall;
    t_out_rsp out_rsp;
    int       fail_count;
    int       pending_rsp;
    int       offered;

    sm4_block_cipher_x4_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp)
    );

    sm4x4_cipher_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_rsp    (out_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // quiet window of 64 requests out of every 256
    function automatic int draw_gap(input int n);
        if ((n / 64) % 4 == 3) return 0;
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [127:0] rand_block();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {rand64(), rand64()};
        endcase
    endfunction

    function automatic t_in_req noise_req();
        t_in_req r;
        r.req_type     = 1'($urandom_range(0, 1));
        r.decrypt      = 1'($urandom_range(0, 1));
        r.key_index    = 5'($urandom_range(0, 31));
        r.key_word     = $urandom();
        r.in_block0_hi = rand64();
        r.in_block0_lo = rand64();
        r.in_block1_hi = rand64();
        r.in_block1_lo = rand64();
        r.in_block2_hi = rand64();
        r.in_block2_lo = rand64();
        r.in_block3_hi = rand64();
        r.in_block3_lo = rand64();
        return r;
    endfunction

    function automatic t_in_req key_req(input logic [4:0] idx, input logic [31:0] word);
        t_in_req r;
        r           = noise_req();
        r.req_type  = REQ_KEY_WRITE;
        r.key_index = idx;
        r.key_word  = word;
        return r;
    endfunction

    function automatic t_in_req block_req(input logic dec, input logic [127:0] b0, b1, b2, b3);
        t_in_req r;
        r          = noise_req();
        r.req_type = REQ_BLOCKS;
        r.decrypt  = dec;
        {r.in_block0_hi, r.in_block0_lo} = b0;
        {r.in_block1_hi, r.in_block1_lo} = b1;
        {r.in_block2_hi, r.in_block2_lo} = b2;
        {r.in_block3_hi, r.in_block3_lo} = b3;
        return r;
    endfunction

    task automatic offer(input t_in_req r);
        int gap;
        gap = draw_gap(offered);
        offered++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge i_clk);
        while (!(in_valid && !in_stall)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [31:0] word;
        int          guard;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_req   = '0;
        offered  = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill every round key before any block request
        for (int k = 0; k < ROUNDS; k++) begin
            case (k)
                0:       word = 32'h0000_0000;
                1:       word = 32'h8000_0000;
                2:       word = 32'h0000_0001;
                31:      word = 32'hffff_ffff;
                default: word = $urandom();
            endcase
            offer(key_req(5'(k), word));
        end
        offer(block_req(1'b0, '0, '0, '0, '0));
        offer(block_req(1'b1, '0, '0, '0, '0));
        offer(block_req(1'b0, '1, '1, '1, '1));
        offer(block_req(1'b1, '1, '1, '1, '1));
        offer(block_req(1'b0, '0, '1, {32{4'ha}}, {32{4'h5}}));
        offer(block_req(1'b1, {32{4'h5}}, {32{4'ha}}, '1, '0));
        offer(key_req(5'd31, $urandom()));
        offer(key_req(5'd0, $urandom()));
        offer(block_req(1'b0, rand_block(), rand_block(), rand_block(), rand_block()));
        offer(block_req(1'b1, rand_block(), rand_block(), rand_block(), rand_block()));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 4) == 0) begin
                offer(key_req(5'($urandom_range(0, 31)), $urandom()));
            end else begin
                offer(block_req(1'($urandom_range(0, 1)),
                                rand_block(), rand_block(), rand_block(), rand_block()));
            end
        end
        in_valid <= 1'b0;

        guard = 0;
        while (pending_rsp != 0 && guard < DRAIN_GUARD) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_rsp == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : receiver
        int gap;
        int taken;
        out_stall = 1'b0;
        taken     = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            // hold off long enough to fill the block and stall its input
            if (taken == HOLD_AT) gap = HOLD_CYCLES;
            else gap = draw_gap(taken);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(out_valid && !out_stall)) @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
